[rtl/core/cc20_pkg.sv]
// cc20_pkg: shared types and constants for the chacha20 stream xor block
// no dependencies; imported by the controller, the datapath and the top level

package cc20_pkg;

    // cipher geometry
    localparam int unsigned WORDS       = 16;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned POS_W       = 7;
    localparam int unsigned DOUBLE_RNDS = 10;
    localparam int unsigned ROUND_STEPS = 4 * 2 * DOUBLE_RNDS;
    localparam int unsigned STEP_W      = 7;

    localparam logic [WORD_W-1:0] CTR_MAX = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0]  POS_EMPTY = POS_W'(BLOCK_BYTES);

    // sigma constants, state words 0 to 3
    localparam logic [WORD_W-1:0] SIGMA [4] = '{
        32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
    };

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0     = 3'd0,
        CFG_KEY_1     = 3'd1,
        CFG_KEY_2     = 3'd2,
        CFG_KEY_3     = 3'd3,
        CFG_NONCE_LO  = 3'd4,
        CFG_NONCE_HI  = 3'd5,
        CFG_INIT_CTR  = 3'd6
    } t_cfg_idx;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       latch;     // capture the input byte
        logic       load;      // working state from the initial state
        logic       round;     // one quarter-round step on all four lanes
        logic [1:0] qstep;     // step within the quarter round
        logic       diag;      // diagonal round when set, column round otherwise
        logic       finish;    // add initial state, bump counter, rewind position
        logic       emit;      // write a keystream-xored result beat
        logic       emit_exh;  // write a counter-exhausted result beat
        logic       src_in;    // emit from the live input byte, else the latched one
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic buf_empty;
        logic ctr_max;
    } t_dp_stat;

endpackage

[rtl/core/cc20_in_if.sv]
// cc20_in_if: input channel of the chacha20 stream xor block, one data byte per beat
// no dependencies

interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;

    modport source (output valid, output data_in, input ready);
    modport sink   (input valid, input data_in, output ready);
endinterface

[rtl/core/cc20_out_if.sv]
// cc20_out_if: result channel of the chacha20 stream xor block
// no dependencies

interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       counter_exhausted;

    modport source (output valid, output data_out, output counter_exhausted, input ready);
    modport sink   (input valid, input data_out, input counter_exhausted, output ready);
endinterface

[rtl/core/cc20_ctrl.sv]
// cc20_ctrl: controller state machine for the chacha20 stream xor block
// depends on cc20_pkg; drives the datapath commands and the handshakes

module cc20_ctrl
    import cc20_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;
    logic              accept;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // state, step counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_cmd.qstep = r_step[1:0];
        o_cmd.diag  = r_step[2];
        o_in_ready  = 1'b0;
        accept      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = out_free;
                accept     = i_in_valid && out_free;
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    if (!i_stat.buf_empty) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.src_in = 1'b1;
                    end else if (i_stat.ctr_max) begin
                        o_cmd.emit_exh = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_step     = '0;
                        n_state    = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_step      = r_step + 1'b1;
                if (r_step == STEP_W'(ROUND_STEPS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // result beat held until taken
        if (o_cmd.emit || o_cmd.emit_exh) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

[rtl/core/cc20_datapath.sv]
// cc20_datapath: key registers, block counter, working state with four quarter-round
// lanes, keystream byte select and the result register; depends on cc20_pkg

module cc20_datapath
    import cc20_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    input  logic [7:0]            i_data_in,
    output t_dp_stat              o_stat,
    output logic [7:0]            o_data_out,
    output logic                  o_counter_exhausted
);

    logic [63:0]       r_key [4];
    logic [63:0]       r_nonce_lo;
    logic [31:0]       r_nonce_hi;
    logic [31:0]       r_init_ctr;
    logic [31:0]       r_ctr;
    logic [POS_W-1:0]  r_pos;
    logic [WORD_W-1:0] r_w [WORDS];
    logic [WORD_W-1:0] n_w [WORDS];
    logic [WORD_W-1:0] init_w [WORDS];
    logic [7:0]        r_din;
    logic [7:0]        r_dout;
    logic              r_exh;
    logic [7:0]        ks_byte;
    logic [7:0]        src_byte;

    // one step of a quarter round on one lane
    function automatic logic [4*WORD_W-1:0] qr_step(
        input logic [1:0]        step,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        logic [WORD_W-1:0] na, nb, nc, nd, t;
        na = a; nb = b; nc = c; nd = d;
        case (step)
            2'd0: begin
                na = a + b; t = d ^ na; nd = {t[15:0], t[31:16]};
            end
            2'd1: begin
                nc = c + d; t = b ^ nc; nb = {t[19:0], t[31:20]};
            end
            2'd2: begin
                na = a + b; t = d ^ na; nd = {t[23:0], t[31:24]};
            end
            default: begin
                nc = c + d; t = b ^ nc; nb = {t[24:0], t[31:25]};
            end
        endcase
        return {na, nb, nc, nd};
    endfunction

    // initial state words
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            init_w[i]         = SIGMA[i];
            init_w[4 + 2*i]   = r_key[i][31:0];
            init_w[5 + 2*i]   = r_key[i][63:32];
        end
        init_w[12] = r_ctr;
        init_w[13] = r_nonce_lo[31:0];
        init_w[14] = r_nonce_lo[63:32];
        init_w[15] = r_nonce_hi;
    end

    // working state update: load, four lanes of quarter-round step, final add
    always_comb begin
        logic [1:0]          lb, lc, ld;
        logic [3:0]          ia, ib, ic, id;
        logic [4*WORD_W-1:0] q;
        n_w = r_w;
        lb  = '0;
        lc  = '0;
        ld  = '0;
        ia  = '0;
        ib  = '0;
        ic  = '0;
        id  = '0;
        q   = '0;
        if (i_cmd.load) begin
            n_w = init_w;
        end else if (i_cmd.round) begin
            for (int lane = 0; lane < 4; lane++) begin
                lb = 2'(lane) + {1'b0, i_cmd.diag};
                lc = 2'(lane) + {i_cmd.diag, 1'b0};
                ld = 2'(lane) + {i_cmd.diag, i_cmd.diag};
                ia = {2'b00, 2'(lane)};
                ib = {2'b01, lb};
                ic = {2'b10, lc};
                id = {2'b11, ld};
                q  = qr_step(i_cmd.qstep, r_w[ia], r_w[ib], r_w[ic], r_w[id]);
                n_w[ia] = q[4*WORD_W-1:3*WORD_W];
                n_w[ib] = q[3*WORD_W-1:2*WORD_W];
                n_w[ic] = q[2*WORD_W-1:WORD_W];
                n_w[id] = q[WORD_W-1:0];
            end
        end else if (i_cmd.finish) begin
            for (int i = 0; i < WORDS; i++) begin
                n_w[i] = r_w[i] + init_w[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    // keystream byte at the current position, little-endian within each word
    assign ks_byte  = r_w[r_pos[5:2]][{r_pos[1:0], 3'b000} +: 8];
    assign src_byte = i_cmd.src_in ? i_data_in : r_din;

    // configuration registers, block counter and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_init_ctr <= '0;
            r_ctr      <= '0;
            r_pos      <= POS_EMPTY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_0:    r_key[0]   <= i_cfg_data;
                CFG_KEY_1:    r_key[1]   <= i_cfg_data;
                CFG_KEY_2:    r_key[2]   <= i_cfg_data;
                CFG_KEY_3:    r_key[3]   <= i_cfg_data;
                CFG_NONCE_LO: r_nonce_lo <= i_cfg_data;
                CFG_NONCE_HI: r_nonce_hi <= i_cfg_data[31:0];
                CFG_INIT_CTR: r_init_ctr <= i_cfg_data[31:0];
                default: ;
            endcase
            case (i_cfg_idx)
                CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3,
                CFG_NONCE_LO, CFG_NONCE_HI: begin
                    r_ctr <= r_init_ctr;
                    r_pos <= POS_EMPTY;
                end
                CFG_INIT_CTR: begin
                    r_ctr <= i_cfg_data[31:0];
                    r_pos <= POS_EMPTY;
                end
                default: ;
            endcase
        end else if (i_cmd.finish) begin
            r_ctr <= r_ctr + 1'b1;
            r_pos <= '0;
        end else if (i_cmd.emit) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    // latched input byte and result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_din <= i_data_in;
        end
        if (i_cmd.emit) begin
            r_dout <= src_byte ^ ks_byte;
            r_exh  <= 1'b0;
        end else if (i_cmd.emit_exh) begin
            r_dout <= '0;
            r_exh  <= 1'b1;
        end
    end

    assign o_stat.buf_empty    = r_pos[POS_W-1];
    assign o_stat.ctr_max      = (r_ctr == CTR_MAX);
    assign o_data_out          = r_dout;
    assign o_counter_exhausted = r_exh;

endmodule

[rtl/core/chacha20_stream_xor.sv]
// chacha20_stream_xor: top level, one data byte in and one result byte out per beat
// depends on cc20_pkg, cc20_in_if, cc20_out_if, cc20_ctrl and cc20_datapath
//
// ChaCha20 (sigma, 256-bit key, 32-bit block counter, 96-bit nonce) in xor mode.
// Each input beat returns data_in xor the next keystream byte. While bytes remain
// in the current 64-byte block the result is registered in the cycle after the beat
// is accepted, and the next beat is accepted in the same cycle that the previous
// result is taken from the output register. The first byte of every block runs in
// order: accept the beat and load the working state, rounds (four quarter-round
// lanes, one add-xor-rotate step each per cycle, 20 rounds of four steps), the final
// state add, then the result write once the output register is free; no beat is
// accepted meanwhile. When a block is needed and the counter stands at 0xFFFFFFFF
// the beat returns zero with counter_exhausted set and nothing changes. Any register
// write reloads the counter from initial_counter and discards the rest of the block;
// write registers only while the block is idle. Reset zeroes key, nonce and counter.

module chacha20_stream_xor
    import cc20_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cc20_in_if.sink               i_in,
    cc20_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing and handshakes
    cc20_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // cipher state and result payload
    cc20_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_cmd               (cmd),
        .i_data_in           (i_in.data_in),
        .o_stat              (stat),
        .o_data_out          (o_out.data_out),
        .o_counter_exhausted (o_out.counter_exhausted)
    );

endmodule
